// ===== rtl/core/inta_pkg.sv =====
// Package for the integer number-theory ALU: opcodes, status codes, payload types.
// No dependencies.
package inta_pkg;
   localparam int unsigned DW = 32;

   typedef enum logic [2:0] {
      OP_LCM = 3'd0, OP_GCD = 3'd1, OP_FACT = 3'd2, OP_POW = 3'd3,
      OP_ADD = 3'd4, OP_SUB = 3'd5, OP_MUL = 3'd6, OP_DIV = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_DIVZERO = 3'd1, ST_NONPOS = 3'd2, ST_NEGFACT = 3'd3,
      ST_LCMOVF = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]     mode;
      logic [DW-1:0]  operand_a;
      logic [DW-1:0]  operand_b;
      logic [DW-1:0]  operand_c;
      logic           three_operands;
   } req_type;

   typedef struct packed {
      logic [DW-1:0] result_value;
      logic [2:0]    status;
   } rsp_type;
endpackage

// ===== rtl/core/integer_number_theory_alu_unit.sv =====
// Top level of the integer number-theory ALU: sequencer, shared multiplier, divider.
// Depends on inta_pkg and inta_divider.
//
//  channel | dir | handshake        | payload
//  req_    | in  | req_valid/ready  | inta_pkg::req_type
//  rsp_    | out | rsp_valid/ready  | inta_pkg::rsp_type
//
// One item at a time. Power: one multiply per cycle; factorial: up to 2*W-2
// multiplies; gcd: one divide per remainder step; lcm adds a divide and one
// multiply. The serial divider serves divide, gcd and lcm. Synchronous reset
// clears control; req_ready is low from acceptance until the result is taken.
module integer_number_theory_alu_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  inta_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output inta_pkg::rsp_type rsp_data
);
   localparam int unsigned W = inta_pkg::DW;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_ARITH, S_POW, S_FACT, S_GCD_DIV, S_GCD_WAIT,
      S_LCM_DIV, S_LCM_WAIT, S_LCM_MUL, S_DIV_WAIT, S_DIV_FIX, S_NEXT, S_DONE
   } state_type;

   state_type           state_ff;
   inta_pkg::op_type    op_ff;
   logic                three_ff, second_ff;
   logic [W-1:0]        a_ff, b_ff, c_ff, x_ff, y_ff, acc_ff, res_ff, g_ff;
   inta_pkg::status_type st_ff;
   logic                neg_ff;

   logic                div_start;
   logic [W-1:0]        div_n, div_d, div_q, div_r;
   logic                div_done;
   logic [W-1:0]        mul_x, mul_y, mul_p;
   logic [2*W-1:0]      mul_wide;
   logic [W-1:0]        opnd;

   assign mul_wide = {{W{1'b0}}, mul_x} * {{W{1'b0}}, mul_y};
   assign mul_p    = mul_wide[W-1:0];
   assign opnd     = second_ff ? c_ff : b_ff;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      mag = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic ispos(input logic [W-1:0] v);
      ispos = (v != '0) && !v[W-1];
   endfunction

   inta_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_n), .divisor(div_d),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   always_comb begin
      div_start = 1'b0;
      div_n = x_ff;
      div_d = y_ff;
      mul_x = acc_ff;
      mul_y = x_ff;
      case (state_ff)
         S_GCD_DIV: div_start = 1'b1;
         S_LCM_DIV: begin
            div_start = 1'b1;
            div_n = acc_ff;
            div_d = g_ff;
         end
         S_LCM_MUL: begin
            mul_x = div_q;
            mul_y = opnd;
         end
         S_ARITH: begin
            mul_x = acc_ff;
            mul_y = opnd;
         end
         S_POW: begin
            mul_x = y_ff[0] ? acc_ff : x_ff;
            mul_y = x_ff;
         end
         S_FACT: begin
            mul_x = acc_ff;
            mul_y = y_ff;
         end
         S_DIV_WAIT: if (x_ff == '0) begin
            // launch on magnitudes, fix the sign afterwards
            div_start = 1'b1;
            div_n = mag(acc_ff);
            div_d = mag(opnd);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               op_ff     <= inta_pkg::op_type'(req_data.mode);
               a_ff      <= W'(req_data.operand_a);
               b_ff      <= W'(req_data.operand_b);
               c_ff      <= W'(req_data.operand_c);
               three_ff  <= req_data.three_operands;
               second_ff <= 1'b0;
               st_ff     <= inta_pkg::ST_OK;
               state_ff  <= S_CHECK;
            end
            S_CHECK: begin
               case (op_ff)
                  inta_pkg::OP_LCM, inta_pkg::OP_GCD: begin
                     acc_ff <= a_ff;
                     if (!ispos(a_ff) || !ispos(b_ff) || (three_ff && !ispos(c_ff))) begin
                        st_ff <= inta_pkg::ST_NONPOS;
                        state_ff <= S_DONE;
                     end else begin
                        x_ff <= a_ff;
                        y_ff <= b_ff;
                        state_ff <= S_GCD_DIV;
                     end
                  end
                  inta_pkg::OP_FACT: begin
                     acc_ff <= W'(1);
                     y_ff   <= W'(2);
                     x_ff   <= a_ff;
                     if (a_ff[W-1]) begin
                        st_ff <= inta_pkg::ST_NEGFACT;
                        state_ff <= S_DONE;
                     end else if (a_ff >= W'(2 * W)) begin
                        res_ff <= '0;
                        state_ff <= S_DONE;
                     end else state_ff <= S_FACT;
                  end
                  inta_pkg::OP_POW: begin
                     acc_ff <= W'(1);
                     x_ff   <= a_ff;
                     y_ff   <= b_ff[W-1] ? '0 : b_ff;
                     state_ff <= S_POW;
                  end
                  inta_pkg::OP_DIV: begin
                     acc_ff <= a_ff;
                     if (b_ff == '0 || (three_ff && c_ff == '0)) begin
                        st_ff <= inta_pkg::ST_DIVZERO;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_DIV_WAIT;
                        x_ff <= '0;
                     end
                  end
                  default: begin
                     acc_ff <= a_ff;
                     state_ff <= S_ARITH;
                  end
               endcase
            end
            S_ARITH: begin
               case (op_ff)
                  inta_pkg::OP_ADD: acc_ff <= acc_ff + opnd;
                  inta_pkg::OP_SUB: acc_ff <= acc_ff - opnd;
                  default:          acc_ff <= mul_p;
               endcase
               state_ff <= S_NEXT;
            end
            S_POW: begin
               // one multiply per cycle: accumulate when the low bit is set, else square
               if (y_ff == '0) begin
                  res_ff <= acc_ff;
                  state_ff <= S_DONE;
               end else if (y_ff[0]) begin
                  acc_ff <= mul_p;
                  y_ff   <= {y_ff[W-1:1], 1'b0};
               end else begin
                  x_ff <= mul_p;
                  y_ff <= y_ff >> 1;
               end
            end
            S_FACT: begin
               if (y_ff > x_ff) begin
                  res_ff <= acc_ff;
                  state_ff <= S_DONE;
               end else begin
                  acc_ff <= mul_p;
                  y_ff   <= y_ff + 1'b1;
               end
            end
            S_GCD_DIV: state_ff <= S_GCD_WAIT;
            S_GCD_WAIT: if (div_done) begin
               if (div_r == '0) begin
                  g_ff <= y_ff;
                  if (op_ff == inta_pkg::OP_LCM) state_ff <= S_LCM_DIV;
                  else begin
                     acc_ff <= y_ff;
                     state_ff <= S_NEXT;
                  end
               end else begin
                  x_ff <= y_ff;
                  y_ff <= div_r;
                  state_ff <= S_GCD_DIV;
               end
            end
            S_LCM_DIV: state_ff <= S_LCM_WAIT;
            S_LCM_WAIT: if (div_done) state_ff <= S_LCM_MUL;
            S_LCM_MUL: begin
               if (mul_wide[2*W-1:W-1] != '0) begin
                  st_ff <= inta_pkg::ST_LCMOVF;
                  state_ff <= S_DONE;
               end else begin
                  acc_ff <= mul_p;
                  state_ff <= S_NEXT;
               end
            end
            S_DIV_WAIT: begin
               // x_ff flags the divider as launched
               if (x_ff == '0) begin
                  x_ff <= W'(1);
                  neg_ff <= acc_ff[W-1] ^ opnd[W-1];
               end else if (div_done) state_ff <= S_DIV_FIX;
            end
            S_DIV_FIX: begin
               acc_ff <= neg_ff ? (~div_q + 1'b1) : div_q;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (three_ff && !second_ff) begin
                  second_ff <= 1'b1;
                  x_ff <= (op_ff == inta_pkg::OP_DIV) ? '0 : acc_ff;
                  y_ff <= c_ff;
                  case (op_ff)
                     inta_pkg::OP_LCM, inta_pkg::OP_GCD: state_ff <= S_GCD_DIV;
                     inta_pkg::OP_DIV: state_ff <= S_DIV_WAIT;
                     default: state_ff <= S_ARITH;
                  endcase
               end else begin
                  res_ff <= acc_ff;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data.result_value = (st_ff == inta_pkg::ST_OK) ? res_ff : '0;
   assign rsp_data.status = st_ff;

`ifndef ASSERT_OFF
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != inta_pkg::ST_OK |-> rsp_data.result_value == '0)
      else $error("nonzero result on error");
`endif
endmodule

// ===== rtl/core/inta_divider.sv =====
// Shared restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Uses no package items.
module inta_divider #(
   parameter int unsigned W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider busy at done");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff) else $error("divider quit early");
`endif
endmodule
